FILE: design/line_width_byte_assembler_macros.svh
// ----------------------------------------------------------------------------
// line_width_byte_assembler_macros
// assertion shorthands used by the checker file lwba_chk
// ----------------------------------------------------------------------------
`ifndef LINE_WIDTH_BYTE_ASSEMBLER_MACROS_SVH
`define LINE_WIDTH_BYTE_ASSEMBLER_MACROS_SVH

// same-cycle implication, reset masked
`define LWBA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define LWBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lwba_pkg.sv
// ----------------------------------------------------------------------------
// lwba_pkg
// shared types and constants of the line width byte assembler
// ----------------------------------------------------------------------------
`default_nettype none

package lwba_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_LINE_BUDGET  = 3'd0;
  localparam logic [2:0] REG_LETTER_WIDTH = 3'd1;
  localparam logic [2:0] REG_LETTER_COST  = 3'd2;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd3;
  localparam logic [2:0] REG_GLYPH_COST   = 3'd4;

  // register widths and reset values
  localparam int unsigned REG_W = 7;
  localparam logic [REG_W-1:0] RST_LINE_BUDGET  = 7'd48;
  localparam logic [REG_W-1:0] RST_LETTER_WIDTH = 7'd1;
  localparam logic [REG_W-1:0] RST_LETTER_COST  = 7'd1;
  localparam logic [REG_W-1:0] RST_GLYPH_WIDTH  = 7'd2;
  localparam logic [REG_W-1:0] RST_GLYPH_COST   = 7'd1;
  localparam logic [REG_W-1:0] UNITS_MAX        = 7'h7F;

  // special bytes
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam int unsigned GLYPH_BIT   = 7;
  localparam int unsigned GLYPH_BYTES = 2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } ctrl_state_e;

  // datapath to controller
  typedef struct packed {
    logic need_drain;  // accepted byte starts a line flush
    logic at_last;     // shown item closes the line
  } lwba_sts_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input transaction this cycle
    logic step;        // output transaction this cycle
    logic done;        // final output transaction of the line
  } lwba_cmd_t;

endpackage

`default_nettype wire

FILE: design/lwba_ram.sv
// ----------------------------------------------------------------------------
// lwba_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lwba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/lwba_ctrl.sv
// ----------------------------------------------------------------------------
// lwba_ctrl
// handshake controller: takes bytes while idle, walks the line out on a flush
// ----------------------------------------------------------------------------
`default_nettype none

module lwba_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  input  wire lwba_pkg::lwba_sts_t sts_i,
  output      lwba_pkg::lwba_cmd_t cmd_o
);

  lwba_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lwba_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.need_drain) begin
          state_d = lwba_pkg::ST_DRAIN;
        end
      end
      lwba_pkg::ST_DRAIN: begin
        if (out_ready_i && sts_i.at_last) begin
          state_d = lwba_pkg::ST_IDLE;
        end
      end
      default: state_d = lwba_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      lwba_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lwba_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i;
        cmd_o.done  = out_ready_i && sts_i.at_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lwba_dp.sv
// ----------------------------------------------------------------------------
// lwba_dp
// datapath: registers, budget check, line store and drain pointer
// ----------------------------------------------------------------------------
`default_nettype none

module lwba_dp #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [lwba_pkg::REG_W-1:0]    cfg_wdata_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire lwba_pkg::lwba_cmd_t           cmd_i,
  output      lwba_pkg::lwba_sts_t           sts_o,
  output      logic [7:0]                    line_byte_o,
  output      logic                          byte_present_o,
  output      logic                          line_last_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned RW = lwba_pkg::REG_W;
  localparam logic [FW-1:0] CAP = FW'(BUFFER_BYTES);

  // configuration registers
  logic [RW-1:0] budget_q, let_w_q, let_c_q, gly_w_q, gly_c_q;

  // line state
  logic [FW-1:0] fill_q, fill_d;
  logic [RW-1:0] used_q, used_d;
  logic          glyph_q, glyph_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]    byte_q;
  logic          pend_q, pend_d;

  // decode and budget check
  logic          is_lf, is_cr, is_glyph, flush, store_now;
  logic [RW-1:0] rest, cost, base;
  logic [RW:0]   sum;
  logic [FW:0]   fill_two;

  // store port
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= lwba_pkg::RST_LINE_BUDGET;
      let_w_q  <= lwba_pkg::RST_LETTER_WIDTH;
      let_c_q  <= lwba_pkg::RST_LETTER_COST;
      gly_w_q  <= lwba_pkg::RST_GLYPH_WIDTH;
      gly_c_q  <= lwba_pkg::RST_GLYPH_COST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lwba_pkg::REG_LINE_BUDGET:  budget_q <= cfg_wdata_i;
        lwba_pkg::REG_LETTER_WIDTH: let_w_q  <= cfg_wdata_i;
        lwba_pkg::REG_LETTER_COST:  let_c_q  <= cfg_wdata_i;
        lwba_pkg::REG_GLYPH_WIDTH:  gly_w_q  <= cfg_wdata_i;
        lwba_pkg::REG_GLYPH_COST:   gly_c_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // byte class, remaining budget and flush decision
  always_comb begin
    is_lf    = (rx_byte_i == lwba_pkg::CHAR_LF);
    is_cr    = (rx_byte_i == lwba_pkg::CHAR_CR);
    is_glyph = rx_byte_i[lwba_pkg::GLYPH_BIT];
    rest     = (budget_q > used_q) ? (budget_q - used_q) : '0;
    fill_two = {1'b0, fill_q} + (FW + 1)'(lwba_pkg::GLYPH_BYTES);
    if (is_glyph) begin
      cost = gly_c_q;
      if (!glyph_q) begin
        flush = (rest < gly_w_q) || (fill_two > {1'b0, CAP});
      end else begin
        flush = (fill_q >= CAP);
      end
    end else begin
      cost  = let_c_q;
      flush = (rest < let_w_q) || (fill_q >= CAP);
    end
    base      = flush ? '0 : used_q;
    sum       = {1'b0, base} + {1'b0, cost};
    store_now = !is_lf && !is_cr && !flush;
  end

  assign sts_o.need_drain = is_lf || (!is_cr && flush);
  assign sts_o.at_last    = (fill_q == '0) || ({1'b0, ptr_q} + FW'(1) == fill_q);

  // next line state
  always_comb begin
    fill_d  = fill_q;
    used_d  = used_q;
    glyph_d = glyph_q;
    pend_d  = pend_q;
    ptr_d   = ptr_q;
    if (cmd_i.accept) begin
      ptr_d  = '0;
      pend_d = !is_lf && !is_cr;
      if (is_lf) begin
        used_d = '0;
      end else if (!is_cr) begin
        used_d = sum[RW] ? lwba_pkg::UNITS_MAX : sum[RW-1:0];
        if (is_glyph) begin
          glyph_d = !glyph_q;
        end
        if (store_now) begin
          fill_d = fill_q + FW'(1);
        end
      end
    end else if (cmd_i.done) begin
      fill_d = pend_q ? FW'(1) : '0;
      pend_d = 1'b0;
    end else if (cmd_i.step) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      used_q  <= '0;
      glyph_q <= 1'b0;
      pend_q  <= 1'b0;
      ptr_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      used_q  <= used_d;
      glyph_q <= glyph_d;
      pend_q  <= pend_d;
      ptr_q   <= ptr_d;
    end
  end

  // held byte for a store after the flush
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= rx_byte_i;
    end
  end

  // store write: now, or at slot zero once the flush is out
  always_comb begin
    we    = 1'b0;
    waddr = fill_q[AW-1:0];
    wdata = rx_byte_i;
    if (cmd_i.accept && store_now) begin
      we = 1'b1;
    end else if (cmd_i.done && pend_q) begin
      we    = 1'b1;
      waddr = '0;
      wdata = byte_q;
    end
  end

  // read address is ptr_d, so the registered rdata shows entry ptr_q
  lwba_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  // output item
  assign byte_present_o = (fill_q != '0);
  assign line_byte_o    = byte_present_o ? rdata : 8'h00;
  assign line_last_o    = sts_o.at_last;

endmodule

`default_nettype wire

FILE: design/line_width_byte_assembler.sv
// ----------------------------------------------------------------------------
// line_width_byte_assembler
// collects text bytes into width-limited lines and streams each line out
// ----------------------------------------------------------------------------
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  tdata = rx_byte
//  m_axis    out   m_axis_tvalid / m_axis_tready  tdata = line_byte,
//                                                 tuser = byte_present,
//                                                 tlast = line_last
//  cfg       in    cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
//  a byte that does not flush is taken while idle; a flush accepts its byte,
//  then walks out the output items, the stored bytes or the single empty-line
//  item, from a line store with one registered read port that gives out one
//  entry a cycle while m_axis_tready is high.
//  s_axis_tready is low while a line drains; m_axis_tready low holds the item.
//  reset clears the counters and state, the line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module line_width_byte_assembler #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // rx_byte [7:0]
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  // line_byte [7:0]
  output      logic [7:0] m_axis_tdata,
  // byte_present [0]
  output      logic       m_axis_tuser,
  output      logic       m_axis_tlast,
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [6:0] cfg_wdata_i
);

  lwba_pkg::lwba_sts_t sts;
  lwba_pkg::lwba_cmd_t cmd;

  // handshake controller
  lwba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // line datapath
  lwba_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_i      (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .line_byte_o    (m_axis_tdata),
    .byte_present_o (m_axis_tuser),
    .line_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: design/lwba_chk.sv
// ----------------------------------------------------------------------------
// lwba_chk
// port-level checks of the line width byte assembler
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_width_byte_assembler_macros.svh"

module lwba_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready
);

  // no input taken while a line drains
  `LWBA_ASSERT_NOW(a_drain_blocks_input, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input ready during drain")

  // an empty line is a single zero item that closes the line
  `LWBA_ASSERT_NOW(a_empty_line, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'h00), "malformed empty line item")

  // a newline transaction always starts a line output
  `LWBA_ASSERT_NEXT(a_newline_flushes, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tdata == lwba_pkg::CHAR_LF), m_axis_tvalid, "newline without line output")

  // the closing transaction of a line ends the drain
  `LWBA_ASSERT_NEXT(a_last_ends_drain, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "output continues after last")

  // stalled output item holds
  `LWBA_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled item changed")

endmodule

bind line_width_byte_assembler lwba_chk u_lwba_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// line width byte assembler: received bytes are streamed in through random
// gaps and output stalls, a model of the line store and the width budget
// predicts every emitted line byte, and each output transaction is checked
// field by field, across several register settings including the extremes
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned STORE_CAP = 64;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       byte_present;
    logic       line_last;
  } line_item_t;

  // dut ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] s_tdata = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [6:0] cfg_wdata = '0;

  // shadow registers and line state
  logic [6:0] budget_q       = lwba_pkg::RST_LINE_BUDGET;
  logic [6:0] letter_width_q = lwba_pkg::RST_LETTER_WIDTH;
  logic [6:0] letter_cost_q  = lwba_pkg::RST_LETTER_COST;
  logic [6:0] glyph_width_q  = lwba_pkg::RST_GLYPH_WIDTH;
  logic [6:0] glyph_cost_q   = lwba_pkg::RST_GLYPH_COST;
  logic [7:0] line_copy [STORE_CAP];
  int         fill_level = 0;
  int         used_units = 0;
  bit         mid_glyph = 1'b0;

  // stimulus and expectation stores
  logic [7:0] rx_backlog [$];
  line_item_t pending_line_bytes [$];
  bit         tx_busy = 1'b0;
  bit         idling_on = 1'b1;
  int         tx_gap = 0;
  int         rx_stall = 0;
  int         mismatch_count = 0;

  line_width_byte_assembler #(
    .BUFFER_BYTES(STORE_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_tdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // push the stored line as expected output, or one empty marker
  function automatic void emit_line();
    if (fill_level == 0) begin
      pending_line_bytes.push_back('{line_byte: 8'h00, byte_present: 1'b0, line_last: 1'b1});
    end else begin
      for (int i = 0; i < fill_level; i++) begin
        pending_line_bytes.push_back('{line_byte: line_copy[i], byte_present: 1'b1,
                                       line_last: (i == fill_level - 1)});
      end
    end
    fill_level = 0;
    used_units = 0;
  endfunction

  // budget and store bookkeeping for one accepted byte
  function automatic void assemble_byte(logic [7:0] rx);
    int rest;
    int cost;
    bit flush;
    if (rx == lwba_pkg::CHAR_CR) return;
    if (rx == lwba_pkg::CHAR_LF) begin
      emit_line();
      return;
    end
    rest = (int'(budget_q) > used_units) ? int'(budget_q) - used_units : 0;
    if (rx[lwba_pkg::GLYPH_BIT]) begin
      // a pair never splits: first half needs two free entries
      if (!mid_glyph)
        flush = (rest < int'(glyph_width_q)) ||
                (fill_level + lwba_pkg::GLYPH_BYTES > STORE_CAP);
      else
        flush = (fill_level >= STORE_CAP);
      cost = int'(glyph_cost_q);
      mid_glyph = !mid_glyph;
    end else begin
      flush = (rest < int'(letter_width_q)) || (fill_level >= STORE_CAP);
      cost = int'(letter_cost_q);
    end
    if (flush) emit_line();
    used_units = used_units + cost;
    if (used_units > int'(lwba_pkg::UNITS_MAX)) used_units = int'(lwba_pkg::UNITS_MAX);
    if (fill_level < STORE_CAP) begin
      line_copy[fill_level] = rx;
      fill_level++;
    end
  endfunction

  // input and output transactions, sampled at the rising edge
  always @(posedge clk_i) begin
    line_item_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        assemble_byte(s_tdata);
        tx_busy = 1'b0;
      end
      if (m_tvalid && m_tready) begin
        if (pending_line_bytes.size() == 0) begin
          $error("unexpected output transaction: line_byte %h", m_tdata);
          mismatch_count++;
        end else begin
          want = pending_line_bytes.pop_front();
          if (m_tdata !== want.line_byte) begin
            $error("line_byte: expected %h, got %h", want.line_byte, m_tdata);
            mismatch_count++;
          end
          if (m_tuser !== want.byte_present) begin
            $error("byte_present: expected %b, got %b", want.byte_present, m_tuser);
            mismatch_count++;
          end
          if (m_tlast !== want.line_last) begin
            $error("line_last: expected %b, got %b", want.line_last, m_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // sender and receiver, driven at the falling edge
  always @(negedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst_ni && !tx_busy) begin
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (rx_backlog.size() > 0) begin
        if (idling_on && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 4);
        end else begin
          nxt_data  = rx_backlog.pop_front();
          nxt_valid = 1'b1;
          tx_busy   = 1'b1;
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;

    // output back-pressure bursts
    if (!idling_on) begin
      m_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      rx_stall = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [6:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      lwba_pkg::REG_LINE_BUDGET:  budget_q       = value;
      lwba_pkg::REG_LETTER_WIDTH: letter_width_q = value;
      lwba_pkg::REG_LETTER_COST:  letter_cost_q  = value;
      lwba_pkg::REG_GLYPH_WIDTH:  glyph_width_q  = value;
      lwba_pkg::REG_GLYPH_COST:   glyph_cost_q   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [6:0] budget, logic [6:0] lw, logic [6:0] lc,
                          logic [6:0] gw, logic [6:0] gc);
    write_reg(lwba_pkg::REG_LINE_BUDGET, budget);
    write_reg(lwba_pkg::REG_LETTER_WIDTH, lw);
    write_reg(lwba_pkg::REG_LETTER_COST, lc);
    write_reg(lwba_pkg::REG_GLYPH_WIDTH, gw);
    write_reg(lwba_pkg::REG_GLYPH_COST, gc);
  endtask

  // hold the sender until every expected line byte is out, then settle
  task automatic drain_all();
    while (rx_backlog.size() > 0 || tx_busy) @(posedge clk_i);
    while (pending_line_bytes.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 127));
    while (v == lwba_pkg::CHAR_LF || v == lwba_pkg::CHAR_CR);
    return v;
  endfunction

  // mostly well-formed lines with random content, some noise bytes
  task automatic queue_random_text(int n_items, int long_pct);
    int count;
    int len;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(30, 70)
                                                 : $urandom_range(0, 10);
        for (int u = 0; u < len && count < n_items; u++) begin
          if ($urandom_range(0, 2) == 0) begin
            rx_backlog.push_back(8'h80 | 8'($urandom_range(0, 127)));
            rx_backlog.push_back(8'h80 | 8'($urandom_range(0, 127)));
            count += 2;
          end else begin
            rx_backlog.push_back(rand_letter());
            count++;
          end
          if ($urandom_range(0, 19) == 0) rx_backlog.push_back(lwba_pkg::CHAR_CR);
        end
        if ($urandom_range(0, 9) != 0) begin
          rx_backlog.push_back(lwba_pkg::CHAR_LF);
          count++;
        end
      end else begin
        rx_backlog.push_back(8'($urandom_range(0, 255)));
        count++;
      end
    end
  endtask

  // run limit
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // reset, then directed and random phases
  initial begin
    logic [7:0] basics [15];
    logic [7:0] narrow [7];
    // empty line, ignored cr, extreme bytes, pairs, lone first half across lf
    basics = '{lwba_pkg::CHAR_LF, lwba_pkg::CHAR_CR, 8'h41, 8'h00, 8'h7F,
               lwba_pkg::CHAR_CR, lwba_pkg::CHAR_LF, 8'h80, 8'hFF, lwba_pkg::CHAR_LF,
               8'hC1, lwba_pkg::CHAR_LF, 8'hA2, 8'h55, lwba_pkg::CHAR_LF};
    // budget flush before a pair, no flush on its second half, then a letter
    narrow = '{8'h61, 8'h62, 8'h81, 8'h82, 8'h63, 8'h64, lwba_pkg::CHAR_LF};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (basics[i]) rx_backlog.push_back(basics[i]);
    drain_all();

    set_regs(7'd3, 7'd1, 7'd1, 7'd2, 7'd1);
    foreach (narrow[i]) rx_backlog.push_back(narrow[i]);
    drain_all();

    // zero widths and costs: apart from newlines, only a full store breaks a line
    set_regs(7'd64, 7'd0, 7'd0, 7'd0, 7'd0);
    queue_random_text(60, 50);
    drain_all();

    // smallest budget, largest widths
    set_regs(7'd1, 7'd64, 7'd64, 7'd64, 7'd64);
    queue_random_text(30, 10);
    drain_all();

    // beyond the stated range, used units saturate
    set_regs(7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
    queue_random_text(30, 10);
    drain_all();

    // zero budget with zero widths never flushes on width
    set_regs(7'd0, 7'd0, 7'd64, 7'd0, 7'd64);
    queue_random_text(45, 40);
    drain_all();

    set_regs(lwba_pkg::RST_LINE_BUDGET, lwba_pkg::RST_LETTER_WIDTH,
             lwba_pkg::RST_LETTER_COST, lwba_pkg::RST_GLYPH_WIDTH,
             lwba_pkg::RST_GLYPH_COST);
    queue_random_text(50, 15);
    drain_all();

    repeat (2) begin
      set_regs(7'($urandom_range(1, 64)), 7'($urandom_range(0, 64)),
               7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
               7'($urandom_range(0, 64)));
      queue_random_text(50, 15);
      drain_all();
    end

    // closing stretch without gaps or stalls
    idling_on = 1'b0;
    set_regs(7'($urandom_range(1, 64)), 7'($urandom_range(0, 8)),
             7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)),
             7'($urandom_range(0, 8)));
    queue_random_text(40, 15);
    drain_all();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: line_width_byte_assembler.f
+incdir+design
design/lwba_pkg.sv
design/lwba_ram.sv
design/lwba_ctrl.sv
design/lwba_dp.sv
design/line_width_byte_assembler.sv
design/lwba_chk.sv
tb/testbench.sv
